// ===== hdl/fat_pkg.sv =====
// Shared types and constants for the file allocation table.
// Used by the channel interfaces, the controller, the datapath and the top level.
package fat_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CSR_IDX_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_AREA_BASE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_SIZE = 8'd1;

   localparam logic [DATA_W-1:0] AREA_BASE_RESET = 32'd0;
   localparam logic [DATA_W-1:0] AREA_SIZE_RESET = 32'd16777216;
   localparam logic [DATA_W-1:0] ID_MAX          = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_ALLOCATE = 2'd0,
      ACT_DELETE   = 2'd1,
      ACT_LOOKUP   = 2'd2,
      ACT_CLEAR    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/fat_ifs.sv =====
// Valid/ready channel interfaces of the file allocation table: request,
// response and register write. Depends on fat_pkg.
interface fat_req_if;
   logic                         valid;
   logic                         ready;
   fat_pkg::action_type          action;
   logic [fat_pkg::DATA_W-1:0]   req_size;
   logic [fat_pkg::DATA_W-1:0]   req_id;
   modport source (output valid, action, req_size, req_id, input ready);
   modport sink (input valid, action, req_size, req_id, output ready);
endinterface

interface fat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [fat_pkg::DATA_W-1:0]   result_id;
   logic [fat_pkg::DATA_W-1:0]   result_address;
   modport source (output valid, status, result_id, result_address, input ready);
   modport sink (input valid, status, result_id, result_address, output ready);
endinterface

interface fat_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fat_pkg::CSR_IDX_W-1:0]  index;
   logic [fat_pkg::DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/fat_ctrl.sv =====
// Sequencer of the file allocation table: accepts a request, runs the slot
// scan and commits the result. Depends on fat_pkg.
module fat_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fat_pkg::sts_type sts,
   output fat_pkg::cmd_type cmd
);

   fat_pkg::state_type state_ff;
   fat_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fat_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fat_pkg::ST_SCAN;
            end
         end
         fat_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = fat_pkg::ST_DRAIN;
            end
         end
         fat_pkg::ST_DRAIN: begin
            // The last slot read is folded into the running results here.
            state_in = fat_pkg::ST_COMMIT;
         end
         fat_pkg::ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = fat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fat_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/fat_datapath.sv =====
// Datapath of the file allocation table: slot memories, valid flags, scan
// accumulators, area registers and the response register. Depends on fat_pkg.
module fat_datapath #(
   parameter int SLOTS = fat_pkg::SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fat_pkg::cmd_type             cmd,
   output fat_pkg::sts_type             sts,
   input  fat_pkg::action_type          req_action,
   input  logic [fat_pkg::DATA_W-1:0]   req_size,
   input  logic [fat_pkg::DATA_W-1:0]   req_id,
   fat_rsp_if.source                    rsp_ch,
   fat_csr_if.sink                      csr_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam int DW = fat_pkg::DATA_W;

   // Slot memories; an entry counts only while its valid flag is set.
   logic [DW-1:0] slot_id_mem   [SLOTS];
   logic [DW-1:0] slot_addr_mem [SLOTS];
   logic [DW-1:0] slot_size_mem [SLOTS];
   logic          slot_valid_ff [SLOTS];

   logic [DW-1:0]        base_ff;
   logic [DW-1:0]        area_ff;
   fat_pkg::action_type  act_ff;
   logic [DW-1:0]        rsize_ff;
   logic [DW-1:0]        rid_ff;
   logic [IDX_W-1:0]     idx_ff;

   logic                 rd_live_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [DW-1:0]        rd_id_ff;
   logic [DW-1:0]        rd_addr_ff;
   logic [DW-1:0]        rd_size_ff;

   logic [DW-1:0]        max_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     found_idx_ff;
   logic [DW-1:0]        found_addr_ff;
   logic [DW-1:0]        run_addr_ff;
   logic [DW-1:0]        space_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [DW-1:0]        rsp_id_ff;
   logic [DW-1:0]        rsp_addr_ff;

   logic [DW-1:0]        eff_id;
   logic [DW-1:0]        eff_addr;
   logic                 hit;
   logic [DW-1:0]        new_id;
   logic                 alloc_ok;
   logic                 wr_alloc;
   logic                 wr_delete;
   logic                 wr_clear;
   logic                 done_status;
   logic [DW-1:0]        done_id;
   logic [DW-1:0]        done_addr;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= fat_pkg::AREA_BASE_RESET;
         area_ff <= fat_pkg::AREA_SIZE_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == fat_pkg::CSR_AREA_BASE) begin
            base_ff <= csr_ch.data;
         end else if (csr_ch.index == fat_pkg::CSR_AREA_SIZE) begin
            area_ff <= csr_ch.data;
         end
      end
   end

   assign sts.scan_last = (idx_ff == LAST_IDX);
   assign sts.out_free  = !rsp_valid_ff || rsp_ch.ready;

   // A slot that is not valid reads as all zero.
   assign eff_id   = rd_valid_ff ? rd_id_ff : '0;
   assign eff_addr = rd_valid_ff ? rd_addr_ff : '0;

   always_comb begin
      if (act_ff == fat_pkg::ACT_ALLOCATE) begin
         hit = !rd_valid_ff && (space_ff >= rsize_ff);
      end else begin
         hit = (eff_id == rid_ff);
      end
   end

   assign new_id    = max_ff + 1'b1;
   assign alloc_ok  = found_ff && (max_ff != fat_pkg::ID_MAX);
   assign wr_alloc  = cmd.commit && (act_ff == fat_pkg::ACT_ALLOCATE) && alloc_ok;
   assign wr_delete = cmd.commit && (act_ff == fat_pkg::ACT_DELETE) && found_ff;
   assign wr_clear  = cmd.commit && (act_ff == fat_pkg::ACT_CLEAR);

   always_comb begin
      done_status = 1'b1;
      done_id     = '0;
      done_addr   = '0;
      case (act_ff)
         fat_pkg::ACT_ALLOCATE: begin
            done_status = !alloc_ok;
            if (alloc_ok) begin
               done_id   = new_id;
               done_addr = found_addr_ff;
            end
         end
         fat_pkg::ACT_DELETE: begin
            done_status = !found_ff;
         end
         fat_pkg::ACT_LOOKUP: begin
            done_status = !found_ff;
            if (found_ff) begin
               done_addr = found_addr_ff;
            end
         end
         default: begin
            done_status = 1'b0;
         end
      endcase
   end

   // Request latch and scan counter.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         rsize_ff <= req_size;
         rid_ff   <= req_id;
         idx_ff   <= '0;
      end else if (cmd.step && !sts.scan_last) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Slot memories: one registered read and one write per cycle.
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rd_id_ff   <= slot_id_mem[idx_ff];
         rd_addr_ff <= slot_addr_mem[idx_ff];
         rd_size_ff <= slot_size_mem[idx_ff];
         rd_valid_ff <= slot_valid_ff[idx_ff];
         rd_idx_ff  <= idx_ff;
      end
      if (wr_alloc) begin
         slot_id_mem[found_idx_ff]   <= new_id;
         slot_addr_mem[found_idx_ff] <= found_addr_ff;
         slot_size_mem[found_idx_ff] <= rsize_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || wr_clear) begin
         for (int k = 0; k < SLOTS; k++) begin
            slot_valid_ff[k] <= 1'b0;
         end
      end else if (wr_alloc) begin
         slot_valid_ff[found_idx_ff] <= 1'b1;
      end else if (wr_delete) begin
         slot_valid_ff[found_idx_ff] <= 1'b0;
      end
   end

   // Scan accumulators. Occupied slots before the first fit advance the
   // running address and shrink the free space; the highest id spans all.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         max_ff      <= '0;
         found_ff    <= 1'b0;
         run_addr_ff <= base_ff;
         space_ff    <= area_ff;
      end else if (rd_live_ff) begin
         if (eff_id > max_ff) begin
            max_ff <= eff_id;
         end
         if (!found_ff) begin
            if (hit) begin
               found_ff      <= 1'b1;
               found_idx_ff  <= rd_idx_ff;
               found_addr_ff <= (act_ff == fat_pkg::ACT_ALLOCATE) ? run_addr_ff : eff_addr;
            end else if (rd_valid_ff) begin
               run_addr_ff <= run_addr_ff + rd_size_ff;
               space_ff    <= space_ff - rd_size_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= done_status;
         rsp_id_ff     <= done_id;
         rsp_addr_ff   <= done_addr;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_id      = rsp_id_ff;
   assign rsp_ch.result_address = rsp_addr_ff;

endmodule

// ===== hdl/file_allocation_table.sv =====
// Top level of the first-fit file allocation table.
// Depends on fat_pkg, fat_ifs, fat_ctrl and fat_datapath.
//
//   channel  direction  word carries                            accepted when
//   req_ch   in         action, req_size, req_id                valid && ready
//   rsp_ch   out        status, result_id, result_address       valid && ready
//   csr_ch   in         index (0 area_base, 1 area_size), data  valid && ready
//
// After a request word is accepted, the slots are read one per cycle, the last read is
// folded in, and the result is committed once rsp_ch has room for the response word.
// Requests are taken one at a time; req_ch is ready again the cycle after the commit.
// Reset is synchronous and clears the slot valid flags at once; there is no
// clearing pass. A response waiting on rsp_ch holds the next commit, while the
// next request word may already be accepted and scanned.
module file_allocation_table #(
   parameter int SLOTS = fat_pkg::SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fat_req_if.sink   req_ch,
   fat_rsp_if.source rsp_ch,
   fat_csr_if.sink   csr_ch
);

   fat_pkg::cmd_type cmd;
   fat_pkg::sts_type sts;
   logic             req_ready;

   assign req_ch.ready = req_ready;

   fat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fat_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_action (req_ch.action),
      .req_size   (req_ch.req_size),
      .req_id     (req_ch.req_id),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch)
   );

`ifndef ASSERT_OFF
   // A result is only written into a free or draining response register.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while response register is occupied");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_ch.valid)
      else $error("response not presented after commit");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (cmd.load && !cmd.step && !cmd.commit))
      else $error("accepted request word not loaded alone");

   a_scan_then_commit: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && sts.scan_last) |=> (!cmd.step && !cmd.commit && !req_ch.ready))
      else $error("scan end not followed by drain cycle");
`endif

endmodule
